// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define DKCT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DKCT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define DKCT_ASSERT(lbl, clk, rstn, prop, msg)
`define DKCT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ----- rtl/core/dkct_pkg.sv -----
// shared types and constants of the distinct key count tables
package dkct_pkg;

    localparam int KEY_W           = 64;
    localparam int CNT_W           = 16;
    localparam int HOST_SLOT_OUT_W = 7;
    localparam int PROC_SLOT_OUT_W = 9;
    localparam int S_TDATA_W       = 5 * KEY_W;
    localparam int M_FIELDS_W      = 4 + HOST_SLOT_OUT_W + PROC_SLOT_OUT_W + 2 * CNT_W;
    localparam int M_TDATA_W       = 56;
    localparam int M_PAD_W         = M_TDATA_W - M_FIELDS_W;
    localparam int APB_ADDR_W      = 4;
    localparam int APB_DATA_W      = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // input field offsets in s_tdata
    localparam int OFS_PREFIX  = 0;
    localparam int OFS_VERSION = KEY_W;
    localparam int OFS_KIND    = 2 * KEY_W;
    localparam int OFS_RELEASE = 3 * KEY_W;
    localparam int OFS_HOST    = 4 * KEY_W;

    // register select, paddr bit 3
    localparam logic REG_PREFIX  = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    typedef struct packed {
        logic load_in;
        logic start;
        logic commit;
        logic load_out;
    } dkct_cmd_t;

    typedef struct packed {
        logic matched;
        logic host_done;
        logic proc_done;
        logic out_free;
    } dkct_stat_t;

    typedef struct packed {
        logic start;
        logic commit;
    } dkct_tcmd_t;

endpackage

// ----- rtl/core/distinct_key_count_tables_core.sv -----
// top level of the distinct key count tables with its apb register file
// a record that does not match skips both table scans and goes straight to its result,
// else both tables are scanned and committed, a found key ends its scan early
// one record at a time: a new record is accepted only once the last result is in the output register,
// both tables scanned side by side, one table entry read per cycle from each table memory
// reset: synchronous active low; clears the fill counts, control state and apb registers, memories keep content
module distinct_key_count_tables_core #(
    parameter int HOST_SLOTS = 128,
    parameter int PROC_SLOTS = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // addr_prefix, format_version, kind_id, kind_release, host_id
    input  logic [dkct_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // host_hit, host_added, host_slot, host_total, proc_hit, proc_added, proc_slot,
    // proc_total, zero pad
    output logic [dkct_pkg::M_TDATA_W-1:0]   m_tdata,
    // matched
    output logic                             m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dkct_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dkct_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dkct_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import dkct_pkg::*;

    logic [KEY_W-1:0] exp_prefix_reg;
    logic [KEY_W-1:0] exp_version_reg;
    logic             reg_sel;
    dkct_cmd_t        cmd;
    dkct_stat_t       stat;

    assign reg_sel = paddr[3];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_prefix_reg  <= '0;
            exp_version_reg <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_PREFIX:  exp_prefix_reg  <= pwdata;
                REG_VERSION: exp_version_reg <= pwdata;
                default:     exp_prefix_reg  <= exp_prefix_reg;
            endcase
        end
    end

    assign prdata = (reg_sel == REG_VERSION) ? exp_version_reg : exp_prefix_reg;

    dkct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dkct_datapath #(
        .HOST_SLOTS (HOST_SLOTS),
        .PROC_SLOTS (PROC_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .exp_prefix  (exp_prefix_reg),
        .exp_version (exp_version_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ----- rtl/core/dkct_table.sv -----
// find-or-insert key table with saturating counts, scanned one entry per cycle
`include "assert_macros.svh"

module dkct_table #(
    parameter int SLOTS      = 128,
    parameter int KEY_BITS   = 64,
    parameter int SLOT_OUT_W = 7
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dkct_pkg::dkct_tcmd_t      cmd,
    input  logic [KEY_BITS-1:0]       key,
    output logic                      done,
    output logic                      hit,
    output logic                      added,
    output logic [SLOT_OUT_W-1:0]     slot,
    output logic [dkct_pkg::CNT_W-1:0] total
);
    import dkct_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    logic [KEY_BITS-1:0] key_mem [SLOTS];
    logic [CNT_W-1:0]    cnt_mem [SLOTS];

    logic [IW-1:0]       used_reg;
    logic                scan_reg;
    logic                rd_vld_reg;
    logic                found_reg;
    logic [IW-1:0]       idx_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic [IW-1:0]       hit_slot_reg;
    logic [CNT_W-1:0]    hit_cnt_reg;
    logic                hit_res_reg;
    logic                added_res_reg;
    logic [IW-1:0]       slot_res_reg;
    logic [CNT_W-1:0]    total_res_reg;

    logic                   rd_match;
    logic                   issue;
    logic                   can_add;
    logic                   take;
    logic [IW-1:0]          sel_slot;
    logic [CNT_W-1:0]       cur_cnt;
    logic [CNT_W-1:0]       new_cnt;
    logic [IW+SLOT_OUT_W-1:0] slot_ext;

    assign rd_match = rd_vld_reg && (rd_key_reg == key);
    assign issue    = scan_reg && !found_reg && !rd_match && (idx_reg != used_reg);
    assign done     = scan_reg && (found_reg || (!rd_vld_reg && (idx_reg == used_reg)));
    assign can_add  = !found_reg && (used_reg != LAST);
    assign take     = found_reg || can_add;
    assign sel_slot = found_reg ? hit_slot_reg : used_reg;
    assign cur_cnt  = found_reg ? hit_cnt_reg : '0;
    assign new_cnt  = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= '0;
            scan_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else if (cmd.start) begin
            scan_reg   <= 1'b1;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else if (cmd.commit) begin
            scan_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            if (can_add) begin
                used_reg <= used_reg + IW'(1);
            end
        end else begin
            rd_vld_reg <= issue;
            if (rd_match) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            idx_reg <= '0;
        end else if (issue) begin
            idx_reg    <= idx_reg + IW'(1);
            rd_idx_reg <= idx_reg;
        end
        if (rd_match && !found_reg) begin
            hit_slot_reg <= rd_idx_reg;
            hit_cnt_reg  <= rd_cnt_reg;
        end
        if (cmd.commit) begin
            hit_res_reg   <= take;
            added_res_reg <= can_add;
            slot_res_reg  <= take ? sel_slot : '0;
            total_res_reg <= take ? new_cnt : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && take) begin
            cnt_mem[sel_slot] <= new_cnt;
        end
        if (cmd.commit && can_add) begin
            key_mem[used_reg] <= key;
        end
        if (issue) begin
            rd_key_reg <= key_mem[idx_reg];
            rd_cnt_reg <= cnt_mem[idx_reg];
        end
    end

    assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_res_reg};
    assign slot     = slot_ext[SLOT_OUT_W-1:0];
    assign hit      = hit_res_reg;
    assign added    = added_res_reg;
    assign total    = total_res_reg;

    `DKCT_ASSERT(a_rd_in_scan, aclk, aresetn, rd_vld_reg |-> scan_reg, "read outside a scan")
    `DKCT_ASSERT(a_commit_done, aclk, aresetn, cmd.commit |-> done, "commit before scan end")
    `DKCT_ASSERT(a_idx_bound, aclk, aresetn, scan_reg |-> (idx_reg <= used_reg),
                 "scan index past used slots")

endmodule

// ----- rtl/core/dkct_datapath.sv -----
// input register, match check, both key tables and the result register
module dkct_datapath #(
    parameter int HOST_SLOTS = 128,
    parameter int PROC_SLOTS = 512
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dkct_pkg::dkct_cmd_t             cmd,
    output dkct_pkg::dkct_stat_t            stat,
    input  logic [dkct_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [dkct_pkg::KEY_W-1:0]      exp_prefix,
    input  logic [dkct_pkg::KEY_W-1:0]      exp_version,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dkct_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser
);
    import dkct_pkg::*;

    logic [S_TDATA_W-1:0] in_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic                       matched;
    dkct_tcmd_t                 tcmd;
    logic                       h_done, h_hit, h_added;
    logic [HOST_SLOT_OUT_W-1:0] h_slot;
    logic [CNT_W-1:0]           h_total;
    logic                       p_done, p_hit, p_added;
    logic [PROC_SLOT_OUT_W-1:0] p_slot;
    logic [CNT_W-1:0]           p_total;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_tdata;
        end
    end

    assign matched = (in_reg[OFS_PREFIX +: KEY_W] == exp_prefix)
                  && (in_reg[OFS_VERSION +: KEY_W] == exp_version);

    assign tcmd.start  = cmd.start;
    assign tcmd.commit = cmd.commit;

    dkct_table #(
        .SLOTS      (HOST_SLOTS),
        .KEY_BITS   (KEY_W),
        .SLOT_OUT_W (HOST_SLOT_OUT_W)
    ) u_host (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tcmd),
        .key     (in_reg[OFS_HOST +: KEY_W]),
        .done    (h_done),
        .hit     (h_hit),
        .added   (h_added),
        .slot    (h_slot),
        .total   (h_total)
    );

    dkct_table #(
        .SLOTS      (PROC_SLOTS),
        .KEY_BITS   (2 * KEY_W),
        .SLOT_OUT_W (PROC_SLOT_OUT_W)
    ) u_proc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tcmd),
        .key     ({in_reg[OFS_RELEASE +: KEY_W], in_reg[OFS_KIND +: KEY_W]}),
        .done    (p_done),
        .hit     (p_hit),
        .added   (p_added),
        .slot    (p_slot),
        .total   (p_total)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tuser_reg <= matched;
            m_tdata_reg <= matched ? {{M_PAD_W{1'b0}}, p_total, p_slot, p_added, p_hit,
                                      h_total, h_slot, h_added, h_hit}
                                   : '0;
        end
    end

    assign stat.matched   = matched;
    assign stat.host_done = h_done;
    assign stat.proc_done = p_done;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/core/dkct_ctrl.sv -----
// controller sequencing accept, match check, table scans and commit (matching records only) and result transfer
`include "assert_macros.svh"

module dkct_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  dkct_pkg::dkct_stat_t stat,
    output dkct_pkg::dkct_cmd_t  cmd
);
    import dkct_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready_reg) begin
                        state_reg    <= ST_CHECK;
                        s_tready_reg <= 1'b0;
                    end
                end
                ST_CHECK: begin
                    state_reg <= stat.matched ? ST_SCAN : ST_EMIT;
                end
                ST_SCAN: begin
                    if (stat.host_done && stat.proc_done) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (stat.out_free) begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready     = s_tready_reg;
    assign cmd.load_in  = (state_reg == ST_IDLE) && s_tvalid && s_tready_reg;
    assign cmd.start    = (state_reg == ST_CHECK) && stat.matched;
    assign cmd.commit   = (state_reg == ST_COMMIT);
    assign cmd.load_out = (state_reg == ST_EMIT) && stat.out_free;

    `DKCT_ASSERT(a_commit_after_scans, aclk, aresetn,
                 cmd.commit |-> $past(stat.host_done && stat.proc_done), "commit without scans")
    `DKCT_ASSERT(a_ready_idle, aclk, aresetn, s_tready_reg |-> (state_reg == ST_IDLE),
                 "ready outside idle")
    `DKCT_ASSERT(a_accept_check, aclk, aresetn,
                 cmd.load_in |=> ((state_reg == ST_CHECK) && !s_tready_reg),
                 "accepted transfer not checked")

endmodule
